// ----- hw/rtl/kbd_pkg.sv -----
// Shared types, codes and lookup functions of the keyed byte decoder.
package kbd_pkg;

    // Counters hold up to 127.
    localparam int KBD_CNT_W = 7;

    // Decode variants selected by the variant_mode register.
    localparam logic [2:0] MODE_XOR            = 3'd0;
    localparam logic [2:0] MODE_ROL_XOR        = 3'd1;
    localparam logic [2:0] MODE_ROR_XOR        = 3'd2;
    localparam logic [2:0] MODE_XOR_INDEX      = 3'd3;
    localparam logic [2:0] MODE_XOR_COUNTER    = 3'd4;
    localparam logic [2:0] MODE_COUNTER_CUMSUM = 3'd5;
    localparam logic [2:0] MODE_ROL_COUNTER    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_KEY_WORD     = 1'b0;
    localparam logic CFG_VARIANT_MODE = 1'b1;

    // Window statistics as they stand after one byte has been folded in.
    typedef struct packed {
        logic [KBD_CNT_W-1:0] run_len;
        logic [KBD_CNT_W-1:0] cyr;
        logic [KBD_CNT_W-1:0] vow;
        logic [KBD_CNT_W-1:0] big;
        logic                 bad;
        logic [7:0]           first;
    } t_win_snap;

    function automatic logic [7:0] rol8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w = {v, v} << n;
        return w[15:8];
    endfunction

    function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] n);
        logic [15:0] w;
        w = {v, v} >> n;
        return w[7:0];
    endfunction

    function automatic logic is_vowel(input logic [7:0] b);
        logic hit;
        case (b)
            8'hc1, 8'hc5, 8'hc9, 8'hcf, 8'hd5, 8'hd9, 8'hc0, 8'hd1, 8'ha3,
            8'he1, 8'he5, 8'he9, 8'hef, 8'hf5, 8'hf9, 8'he0, 8'hf1, 8'hb3: begin
                hit = 1'b1;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    function automatic logic is_pair(input logic [15:0] p);
        logic hit;
        case (p)
            16'hd3d4, 16'hd4cf, 16'hd4d8, 16'hcec1, 16'hd2c1, 16'hd0cf, 16'hd0d2,
            16'hcfd7, 16'hcfc7, 16'hc1ce, 16'hd3cb, 16'hc1d4, 16'hc1de, 16'hd2c5,
            16'hd7c1, 16'hc9cc, 16'hcfce, 16'hcec5, 16'hcdcf, 16'hc9c5, 16'hcfcd,
            16'hcfcb, 16'hcbcf, 16'hc5cb, 16'hc1cc, 16'hcdc5, 16'hc1cd, 16'hd1cd,
            16'hceca, 16'hcad4, 16'hc1d1, 16'hd0d5, 16'hd5d3, 16'hc1da, 16'hd9d4,
            16'hc5d2, 16'hc5d3, 16'hd7c5, 16'hd0c5, 16'hefd0, 16'heed5, 16'hefce,
            16'hf3d4, 16'heec1, 16'he6c1, 16'he9c7, 16'he4c1, 16'h20cd, 16'h20d3,
            16'h20d0, 16'h20d4, 16'h20cb, 16'h20d2: begin
                hit = 1'b1;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

endpackage

// ----- hw/rtl/keyed_byte_decoder_with_text_scoring.sv -----
// Top level of the keyed byte decoder with KOI8-R text scoring.
//
//   Chan | Dir | Handshake                | Payload ports
//   -----+-----+--------------------------+-------------------------------------------
//   in   | in  | i_in_valid / o_in_ready  | i_cipher_byte, i_last_in_window
//   out  | out | o_out_valid / i_out_ready| o_plain_byte .. o_text_score (five fields)
//   cfg  | in  | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// One transaction is taken per cycle while o_in_ready is high and yields one
// result via the snapshot and result stages: the first decodes the byte and
// folds it into the window counters, the second scores the snapshot it leaves.
// Reset is synchronous and active low and clears the key, the variant, the
// window state and both valid flags. An output stall holds the result and then
// the snapshot stage; input ready drops only while both are full and stalled.
module keyed_byte_decoder_with_text_scoring #(
    parameter int WINDOW_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_cipher_byte,
    input  logic        i_last_in_window,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_plain_byte,
    output logic        o_plain_valid,
    output logic        o_window_done,
    output logic [5:0]  o_run_length,
    output logic [10:0] o_text_score
);
    import kbd_pkg::*;

    localparam int POS_W = $clog2(WINDOW_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_BYTES - 1);

    // Configuration.
    logic [63:0] r_key;
    logic [2:0]  r_mode;

    // Window state.
    logic [POS_W-1:0]     r_pos,     n_pos;
    logic [7:0]           r_prev,    n_prev;
    logic                 r_stopped, n_stopped;
    logic [KBD_CNT_W-1:0] r_cyr,     n_cyr;
    logic [KBD_CNT_W-1:0] r_vow,     n_vow;
    logic                 r_bad,     n_bad;
    logic [KBD_CNT_W-1:0] r_big,     n_big;
    logic [7:0]           r_first,   n_first;

    // Snapshot stage.
    logic      r_s1_valid;
    logic [7:0] r_s1_plain, n_s1_plain;
    logic      r_s1_pvalid, n_s1_pvalid;
    logic      r_s1_done,   n_s1_done;
    t_win_snap r_s1_snap,   n_s1_snap;

    // Result stage.
    logic        r_out_valid;
    logic [7:0]  r_out_plain;
    logic        r_out_pvalid;
    logic        r_out_done;
    logic [5:0]  r_out_run;
    logic [10:0] r_out_score;

    logic        w_out_adv;
    logic        w_s1_adv;
    logic        w_accept;
    logic [7:0]  w_key_byte;
    logic [7:0]  w_dec;
    logic [10:0] w_score;

    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_s1_adv   = !r_s1_valid || w_out_adv;
    assign o_in_ready = w_s1_adv;
    assign w_accept   = i_in_valid && w_s1_adv;

    assign w_key_byte = r_key[8 * r_pos[2:0] +: 8];

    kbd_decode u_decode (
        .i_cipher     (i_cipher_byte),
        .i_key_byte   (w_key_byte),
        .i_mode       (r_mode),
        .i_index      (8'(r_pos)),
        .i_block      (8'(r_pos >> 3)),
        .i_first_pos  (r_pos == '0),
        .i_prev_plain (r_prev),
        .o_plain      (w_dec)
    );

    // Fold the accepted byte into the window. The snapshot carries the
    // statistics as they stand before the window end clears them.
    always_comb begin
        logic                 v_last;
        logic [KBD_CNT_W-1:0] v_pos_cnt;

        v_last    = i_last_in_window || (r_pos == LAST_POS);
        v_pos_cnt = KBD_CNT_W'(r_pos);

        n_pos     = r_pos;
        n_prev    = r_prev;
        n_stopped = r_stopped;
        n_cyr     = r_cyr;
        n_vow     = r_vow;
        n_bad     = r_bad;
        n_big     = r_big;
        n_first   = r_first;

        n_s1_plain  = 8'h00;
        n_s1_pvalid = 1'b0;
        n_s1_done   = v_last;

        if (!r_stopped) begin
            n_s1_plain = w_dec;
            if (w_dec == 8'h00) begin
                n_stopped = 1'b1;
            end else begin
                n_s1_pvalid = 1'b1;
                if (w_dec >= 8'hc0 && w_dec != 8'hff) begin
                    n_cyr = r_cyr + KBD_CNT_W'(1);
                end else if (!(w_dec >= 8'h20 && w_dec < 8'h7f)) begin
                    n_bad = 1'b1;
                end
                if (is_vowel(w_dec)) begin
                    n_vow = r_vow + KBD_CNT_W'(1);
                end
                if (r_pos == '0) begin
                    n_first = w_dec;
                end else if (is_pair({r_prev, w_dec})) begin
                    n_big = r_big + KBD_CNT_W'(1);
                end
                n_prev = w_dec;
            end
        end

        // Once the run has stopped, the length is the current position.
        n_s1_snap.run_len = n_stopped ? v_pos_cnt : v_pos_cnt + KBD_CNT_W'(1);
        n_s1_snap.cyr     = n_cyr;
        n_s1_snap.vow     = n_vow;
        n_s1_snap.big     = n_big;
        n_s1_snap.bad     = n_bad;
        n_s1_snap.first   = n_first;

        if (v_last) begin
            n_pos     = '0;
            n_prev    = 8'h00;
            n_stopped = 1'b0;
            n_cyr     = '0;
            n_vow     = '0;
            n_bad     = 1'b0;
            n_big     = '0;
            n_first   = 8'h00;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    kbd_score u_score (
        .i_snap  (r_s1_snap),
        .o_score (w_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_mode      <= MODE_XOR;
            r_pos       <= '0;
            r_prev      <= 8'h00;
            r_stopped   <= 1'b0;
            r_cyr       <= '0;
            r_vow       <= '0;
            r_bad       <= 1'b0;
            r_big       <= '0;
            r_first     <= 8'h00;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_WORD:     r_key  <= i_cfg_data;
                    CFG_VARIANT_MODE: r_mode <= i_cfg_data[2:0];
                    default:          r_key  <= r_key;
                endcase
            end
            if (w_accept) begin
                r_pos     <= n_pos;
                r_prev    <= n_prev;
                r_stopped <= n_stopped;
                r_cyr     <= n_cyr;
                r_vow     <= n_vow;
                r_bad     <= n_bad;
                r_big     <= n_big;
                r_first   <= n_first;
            end
            if (w_s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_plain  <= n_s1_plain;
            r_s1_pvalid <= n_s1_pvalid;
            r_s1_done   <= n_s1_done;
            r_s1_snap   <= n_s1_snap;
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_plain  <= r_s1_plain;
            r_out_pvalid <= r_s1_pvalid;
            r_out_done   <= r_s1_done;
            if (r_s1_done) begin
                r_out_run   <= (r_s1_snap.run_len > KBD_CNT_W'(63)) ? 6'd63
                                                                   : r_s1_snap.run_len[5:0];
                r_out_score <= w_score;
            end else begin
                r_out_run   <= 6'd0;
                r_out_score <= 11'd0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_plain_byte  = r_out_plain;
    assign o_plain_valid = r_out_pvalid;
    assign o_window_done = r_out_done;
    assign o_run_length  = r_out_run;
    assign o_text_score  = r_out_score;

endmodule

// ----- hw/rtl/kbd_decode.sv -----
// Single-byte keyed decoder covering all seven variants.
module kbd_decode (
    input  logic [7:0] i_cipher,
    input  logic [7:0] i_key_byte,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_index,
    input  logic [7:0] i_block,
    input  logic       i_first_pos,
    input  logic [7:0] i_prev_plain,
    output logic [7:0] o_plain
);
    import kbd_pkg::*;

    logic [7:0] w_sum_key;
    logic [7:0] w_cum;

    assign w_sum_key = i_key_byte + i_block;
    assign w_cum     = i_cipher ^ w_sum_key;

    always_comb begin
        case (i_mode)
            MODE_XOR:            o_plain = i_cipher ^ i_key_byte;
            MODE_ROL_XOR:        o_plain = rol8(i_cipher, i_key_byte[2:0]) ^ i_key_byte;
            MODE_ROR_XOR:        o_plain = ror8(i_cipher, i_key_byte[2:0]) ^ i_key_byte;
            MODE_XOR_INDEX:      o_plain = i_cipher ^ i_key_byte ^ i_index;
            MODE_XOR_COUNTER:    o_plain = w_cum;
            MODE_COUNTER_CUMSUM: o_plain = i_first_pos ? w_cum : w_cum + i_prev_plain;
            MODE_ROL_COUNTER:    o_plain = rol8(i_cipher, i_key_byte[2:0]) ^ w_sum_key;
            default:             o_plain = 8'h00;
        endcase
    end

endmodule

// ----- hw/rtl/kbd_score.sv -----
// Text score of one finished window from its collected statistics.
module kbd_score (
    input  kbd_pkg::t_win_snap i_snap,
    output logic [10:0]        o_score
);
    import kbd_pkg::*;

    logic [13:0] w_cyr_pct;
    logic [13:0] w_vow_pct;
    logic [13:0] w_n60;
    logic [13:0] w_n18;
    logic [13:0] w_n66;
    logic [11:0] w_raw;
    logic        w_pass;

    // Truncated ratio tests become exact compares of cross products:
    // floor(a*100/n) < 60 exactly when a*100 < 60*n, and > 65 when >= 66*n.
    assign w_cyr_pct = 14'(i_snap.cyr) * 14'd100;
    assign w_vow_pct = 14'(i_snap.vow) * 14'd100;
    assign w_n60     = 14'(i_snap.run_len) * 14'd60;
    assign w_n18     = 14'(i_snap.run_len) * 14'd18;
    assign w_n66     = 14'(i_snap.run_len) * 14'd66;

    assign w_pass = (i_snap.run_len >= KBD_CNT_W'(5)) && !i_snap.bad
                    && (w_cyr_pct >= w_n60) && (w_vow_pct >= w_n18)
                    && (w_vow_pct < w_n66) && (i_snap.big != '0);

    assign w_raw = 12'(i_snap.cyr) * 12'd5 + 12'(i_snap.big) * 12'd50
                   + (((i_snap.first >= 8'he0) && (i_snap.first <= 8'hfe)) ? 12'd30 : 12'd0);

    assign o_score = !w_pass ? 11'd0 : ((w_raw > 12'd2047) ? 11'd2047 : w_raw[10:0]);

endmodule

// ----- hw/rtl/kbd_checker.sv -----
// Port-level checks of the decoder top level and the bind that attaches them.
module kbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_plain_byte,
    input logic        o_plain_valid,
    input logic        o_window_done,
    input logic [5:0]  o_run_length,
    input logic [10:0] o_text_score
);

    // A stalled result stays offered with the same contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_plain_byte)
            && $stable(o_text_score) && $stable(o_run_length))
        else $error("result changed while stalled");

    // Run length and score are shown only on the window's last byte.
    a_mid_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_done |-> o_run_length == 6'd0 && o_text_score == 11'd0)
        else $error("summary fields set inside a window");

    // A nonzero score needs a run of at least five bytes.
    a_score_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_text_score != 11'd0 |-> o_run_length >= 6'd5)
        else $error("score given for a short run");

    // A byte of the run is never the terminating zero.
    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_plain_valid |-> o_plain_byte != 8'h00)
        else $error("zero byte marked as part of the run");

    // Reset leaves no result offered.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind keyed_byte_decoder_with_text_scoring kbd_checker u_kbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_plain_byte  (o_plain_byte),
    .o_plain_valid (o_plain_valid),
    .o_window_done (o_window_done),
    .o_run_length  (o_run_length),
    .o_text_score  (o_text_score)
);
